// ===== sv/substring_contains_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Substring matcher assertion macros
// Shared concurrent assertion forms for the substring matcher.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_CONTAINS_MATCHER_DEFINES_SVH
`define SUBSTRING_CONTAINS_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring matcher: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring matcher: next-cycle check failed");

`endif

// ===== sv/sccm_pkg.sv =====
// ----------------------------------------------------------------------------
// Substring matcher package
// Item kinds, status codes, compare modes and the ASCII case fold.
// ----------------------------------------------------------------------------
`default_nettype none

package sccm_pkg;

    typedef logic [15:0] t_unit;
    typedef logic [1:0]  t_kind;
    typedef logic [1:0]  t_status;
    typedef logic [2:0]  t_mode;

    localparam t_kind KIND_START    = 2'd0;
    localparam t_kind KIND_NEEDLE   = 2'd1;
    localparam t_kind KIND_HAYSTACK = 2'd2;
    localparam t_kind KIND_FINISH   = 2'd3;

    localparam t_status STATUS_OK           = 2'd0;
    localparam t_status STATUS_NULL_HAY     = 2'd1;
    localparam t_status STATUS_NULL_NEEDLE  = 2'd2;
    localparam t_status STATUS_NEEDLE_LONG  = 2'd3;

    localparam t_mode MODE_FOLD_A = 3'd1;
    localparam t_mode MODE_FOLD_B = 3'd3;
    localparam t_mode MODE_FOLD_C = 3'd5;
    localparam t_mode MODE_RESET  = 3'd4;

    localparam t_unit CHAR_UPPER_A = 16'h0041;
    localparam t_unit CHAR_UPPER_Z = 16'h005A;
    localparam t_unit CHAR_LOWER_A = 16'h0061;

    function automatic t_unit fold_lower(input t_unit c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sccm_item_if.sv =====
// ----------------------------------------------------------------------------
// Substring matcher item channel
// Valid/ready channel carrying one query item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] char_code;
    logic        haystack_missing;
    logic        needle_missing;

    modport source (
        output valid, kind, char_code, haystack_missing, needle_missing,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, haystack_missing, needle_missing,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sccm_result_if.sv =====
// ----------------------------------------------------------------------------
// Substring matcher result channel
// Valid/ready channel carrying one search report per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccm_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       found;

    modport source (
        output valid, status, found,
        input  ready
    );
    modport sink (
        input  valid, status, found,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sccm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Substring matcher configuration channel
// Valid/ready write channel for the compare mode register.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] compare_mode;

    modport source (
        output valid, compare_mode,
        input  ready
    );
    modport sink (
        input  valid, compare_mode,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sccm_window_cmp.sv =====
// ----------------------------------------------------------------------------
// Substring matcher window compare
// Aligns the newest needle-length window units to the needle with a log
// shifter and compares all lanes in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module sccm_window_cmp #(
    parameter int MAX_NEEDLE = 32
) (
    input  sccm_pkg::t_unit                     i_window [MAX_NEEDLE],
    input  sccm_pkg::t_unit                     i_needle [MAX_NEEDLE],
    input  logic [$clog2(MAX_NEEDLE+1)-1:0]     i_count,
    input  logic                                i_fold,
    output logic                                o_hit
);
    import sccm_pkg::*;

    localparam int CW = $clog2(MAX_NEEDLE + 1);
    localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    logic [CW-1:0]   shift_full;
    logic [IW-1:0]   shift_amt;
    t_unit           lvl [IW+1][MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0] lane_ok;
    t_unit           a_unit;
    t_unit           b_unit;

    // Lane i must see window[count-1-i]; reversing the window turns that
    // into a downward shift by MAX_NEEDLE - count.
    assign shift_full = CW'(MAX_NEEDLE) - i_count;
    assign shift_amt  = shift_full[IW-1:0];

    always_comb begin
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            lvl[0][k] = i_window[MAX_NEEDLE-1-k];
        end
        for (int b = 0; b < IW; b++) begin
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                if (!shift_amt[b]) begin
                    lvl[b+1][k] = lvl[b][k];
                end else if (k + (1 << b) < MAX_NEEDLE) begin
                    lvl[b+1][k] = lvl[b][k + (1 << b)];
                end else begin
                    lvl[b+1][k] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            a_unit = i_fold ? fold_lower(lvl[IW][i]) : lvl[IW][i];
            b_unit = i_fold ? fold_lower(i_needle[i]) : i_needle[i];
            lane_ok[i] = (a_unit == b_unit) || (CW'(i) >= i_count);
        end
    end

    assign o_hit = &lane_ok;

endmodule

`default_nettype wire

// ===== sv/substring_contains_matcher.sv =====
// ----------------------------------------------------------------------------
// Substring contains matcher
// Streams a needle and a haystack of UTF-16 units and reports whether the
// needle occurs in the haystack.
// ----------------------------------------------------------------------------
// Items arrive on i_in: start clears the query, needle beats append to the
// needle store, haystack beats shift into the text window and are compared
// against the whole needle at once, and a finish beat yields one report on
// o_out carrying the status and the found flag. Only finish produces a beat.
// One item is taken per cycle while i_in.ready is high. An accepted item
// is held in the input register, where it updates the state; a finish
// report passes from there through the output register onto o_out. The
// window compare is combinational: a log shifter aligns the window to the
// needle and all lanes are compared in parallel.
// When the receiver stalls, the report waits in the output register and
// further items are still taken until a second finish reaches the input
// register; that finish then holds i_in.ready low until o_out drains.
// i_cfg writes compare_mode in one cycle and should only be written while
// idle. Synchronous reset empties both registers, clears the query and sets
// compare_mode to 4 (exact comparison).
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_contains_matcher_defines.svh"

module substring_contains_matcher #(
    parameter int MAX_NEEDLE = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sccm_cfg_if.sink        i_cfg,
    sccm_item_if.sink       i_in,
    sccm_result_if.source   o_out
);
    import sccm_pkg::*;

    localparam int CW = $clog2(MAX_NEEDLE + 1);
    localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    // Input register.
    logic     r_in_valid;
    t_kind    r_in_kind;
    t_unit    r_in_code;
    logic     r_in_hay_null;
    logic     r_in_ndl_null;

    // Query state.
    t_mode         r_mode;
    t_unit         r_needle [MAX_NEEDLE];
    t_unit         r_window [MAX_NEEDLE];
    logic [CW-1:0] r_needle_count;
    logic          r_overflow;
    logic [CW-1:0] r_text_count;
    logic          r_match;

    // Output register.
    logic     r_out_valid;
    t_status  r_out_status;
    logic     r_out_found;

    logic          stall;
    logic          go;
    logic          fold;
    logic          hit;
    t_unit         n_window [MAX_NEEDLE];
    logic [CW-1:0] n_text_count;
    t_status       n_status;

    assign i_cfg.ready = 1'b1;

    assign stall = r_in_valid && (r_in_kind == KIND_FINISH) && r_out_valid && !o_out.ready;
    assign go    = r_in_valid && !stall;
    assign i_in.ready = !stall;

    always_comb begin
        case (r_mode) inside
            MODE_FOLD_A, MODE_FOLD_B, MODE_FOLD_C: fold = 1'b1;
            default:                               fold = 1'b0;
        endcase
    end

    always_comb begin
        n_window[0] = r_in_code;
        for (int k = 1; k < MAX_NEEDLE; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_text_count = (r_text_count < CW'(MAX_NEEDLE)) ? r_text_count + CW'(1)
                                                        : r_text_count;
    end

    sccm_window_cmp #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_cmp (
        .i_window (n_window),
        .i_needle (r_needle),
        .i_count  (r_needle_count),
        .i_fold   (fold),
        .o_hit    (hit)
    );

    always_comb begin
        if (r_in_hay_null) begin
            n_status = STATUS_NULL_HAY;
        end else if (r_in_ndl_null) begin
            n_status = STATUS_NULL_NEEDLE;
        end else if (r_overflow) begin
            n_status = STATUS_NEEDLE_LONG;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_RESET;
            r_needle_count <= '0;
            r_overflow     <= 1'b0;
            r_text_count   <= '0;
            r_match        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.compare_mode;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (go && r_in_kind == KIND_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (go) begin
                case (r_in_kind)
                    KIND_START: begin
                        r_needle_count <= '0;
                        r_overflow     <= 1'b0;
                        r_text_count   <= '0;
                        r_match        <= 1'b0;
                    end
                    KIND_NEEDLE: begin
                        if (r_needle_count < CW'(MAX_NEEDLE)) begin
                            r_needle_count <= r_needle_count + CW'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                    end
                    KIND_HAYSTACK: begin
                        r_text_count <= n_text_count;
                        if (!r_overflow && r_needle_count != '0
                                && n_text_count >= r_needle_count && hit) begin
                            r_match <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_kind     <= i_in.kind;
            r_in_code     <= i_in.char_code;
            r_in_hay_null <= i_in.haystack_missing;
            r_in_ndl_null <= i_in.needle_missing;
        end
        if (go && r_in_kind == KIND_NEEDLE && r_needle_count < CW'(MAX_NEEDLE)) begin
            r_needle[r_needle_count[IW-1:0]] <= r_in_code;
        end
        if (go && r_in_kind == KIND_HAYSTACK) begin
            r_window <= n_window;
        end
        if (go && r_in_kind == KIND_FINISH) begin
            r_out_status <= n_status;
            r_out_found  <= (n_status == STATUS_OK) && (r_needle_count == '0 || r_match);
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.found  = r_out_found;

    `SCCM_ASSERT_IMPL(a_overflow_full, i_clk, i_rst_n, r_overflow, r_needle_count == CW'(MAX_NEEDLE))
    `SCCM_ASSERT_IMPL(a_text_count_sat, i_clk, i_rst_n, 1'b1, r_text_count <= CW'(MAX_NEEDLE))
    `SCCM_ASSERT_IMPL(a_found_only_ok, i_clk, i_rst_n, r_out_valid && r_out_status != STATUS_OK, !r_out_found)
    `SCCM_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, go && r_in_kind == KIND_START, r_needle_count == '0 && r_text_count == '0 && !r_match && !r_overflow)

endmodule

`default_nettype wire

// ===== dv/tb_substring_contains_matcher.sv =====
// ----------------------------------------------------------------------------
// Substring contains matcher testbench
// Drives query beats, compare mode writes and report back-pressure into the
// matcher, predicts every finish report from its own copy of the needle
// store, text window and match flag, and compares each report field by
// field in the order the reports arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_substring_contains_matcher;

    import sccm_pkg::*;

    localparam int    NEEDLE_DEPTH = 32;
    localparam int    PHASE_ITEMS  = 100;
    localparam int    SETTLE_GAP   = 6;
    localparam int    LONG_HOLD    = 150;
    localparam int    CYCLE_LIMIT  = 200000;

    localparam t_mode MODE_EXACT_A = 3'd0;
    localparam t_mode MODE_EXACT_B = 3'd2;
    localparam t_mode MODE_EXACT_C = 3'd6;
    localparam t_mode MODE_EXACT_D = 3'd7;

    typedef struct packed {
        t_status status;
        logic    found;
    } t_report;

    class t_contains_scoreboard;
        t_unit       needle_units [NEEDLE_DEPTH];
        int unsigned needle_len;
        bit          needle_over;
        t_unit       text_units [NEEDLE_DEPTH];
        int unsigned text_len;
        bit          hit_seen;
        t_mode       mode;
        t_report     expected_reports [$];
        int unsigned errors;
        int unsigned reports_checked;

        function new();
            foreach (needle_units[i]) needle_units[i] = '0;
            clear_query();
            mode            = MODE_RESET;
            errors          = 0;
            reports_checked = 0;
        endfunction

        function void clear_query();
            needle_len  = 0;
            needle_over = 1'b0;
            foreach (text_units[i]) text_units[i] = '0;
            text_len    = 0;
            hit_seen    = 1'b0;
        endfunction

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function t_unit lower_ascii(t_unit c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                return c | (CHAR_LOWER_A ^ CHAR_UPPER_A);
            end
            return c;
        endfunction

        function bit units_match(t_unit a, t_unit b);
            if (mode == MODE_FOLD_A || mode == MODE_FOLD_B || mode == MODE_FOLD_C) begin
                return lower_ascii(a) == lower_ascii(b);
            end
            return a == b;
        endfunction

        function void note_item(t_kind k, t_unit c, logic hay_null, logic ndl_null);
            bit      hit;
            t_report rep;
            case (k)
                KIND_START: begin
                    clear_query();
                end
                KIND_NEEDLE: begin
                    if (needle_len < NEEDLE_DEPTH) begin
                        needle_units[needle_len] = c;
                        needle_len++;
                    end else begin
                        needle_over = 1'b1;
                    end
                end
                KIND_HAYSTACK: begin
                    for (int i = NEEDLE_DEPTH - 1; i > 0; i--) text_units[i] = text_units[i-1];
                    text_units[0] = c;
                    if (text_len < NEEDLE_DEPTH) text_len++;
                    if (!needle_over && needle_len > 0 && text_len >= needle_len) begin
                        hit = 1'b1;
                        for (int i = 0; i < needle_len; i++) begin
                            if (!units_match(text_units[needle_len-1-i], needle_units[i])) begin
                                hit = 1'b0;
                            end
                        end
                        if (hit) hit_seen = 1'b1;
                    end
                end
                default: begin
                    rep.found = 1'b0;
                    if (hay_null) begin
                        rep.status = STATUS_NULL_HAY;
                    end else if (ndl_null) begin
                        rep.status = STATUS_NULL_NEEDLE;
                    end else if (needle_over) begin
                        rep.status = STATUS_NEEDLE_LONG;
                    end else begin
                        rep.status = STATUS_OK;
                        rep.found  = (needle_len == 0) || hit_seen;
                    end
                    expected_reports.push_back(rep);
                end
            endcase
        endfunction

        function void check_report(t_status s, logic f);
            t_report want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, status %0d found %0d", $time, s, f);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            if (s !== want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, s);
                errors++;
            end
            if (f !== want.found) begin
                $display("%0t: found mismatch, expected %0d actual %0d",
                         $time, want.found, f);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sccm_cfg_if    cfg_bus ();
    sccm_item_if   item_bus ();
    sccm_result_if res_bus ();

    substring_contains_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (item_bus),
        .o_out   (res_bus)
    );

    t_contains_scoreboard tracker = new();

    int unsigned items_sent   = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                tracker.set_mode(cfg_bus.compare_mode);
            end
            if (item_bus.valid && item_bus.ready) begin
                tracker.note_item(item_bus.kind, item_bus.char_code,
                                  item_bus.haystack_missing, item_bus.needle_missing);
            end
            if (res_bus.valid && res_bus.ready) begin
                tracker.check_report(res_bus.status, res_bus.found);
            end
        end
    end

    task automatic send_item(t_kind k, t_unit c, logic hay_null, logic ndl_null);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            item_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        item_bus.valid            <= 1'b1;
        item_bus.kind             <= k;
        item_bus.char_code        <= c;
        item_bus.haystack_missing <= hay_null;
        item_bus.needle_missing   <= ndl_null;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_unit(t_kind k, t_unit c);
        send_item(k, c, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_finish(logic hay_null, logic ndl_null);
        send_item(KIND_FINISH, t_unit'($urandom_range(65535)), hay_null, ndl_null);
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode m);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.compare_mode <= m;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_unit pick_unit();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            case ($urandom_range(3))
                0:       return CHAR_UPPER_A;
                1:       return t_unit'(CHAR_UPPER_A + 1);
                2:       return CHAR_LOWER_A;
                default: return t_unit'(CHAR_LOWER_A + 1);
            endcase
        end else if (r < 60) begin
            case ($urandom_range(5))
                0:       return t_unit'(CHAR_UPPER_A - 1);
                1:       return t_unit'(CHAR_UPPER_Z + 1);
                2:       return t_unit'(CHAR_LOWER_A - 1);
                3:       return t_unit'(CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A) + 1);
                4:       return CHAR_UPPER_Z;
                default: return CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A);
            endcase
        end else if (r < 80) begin
            return t_unit'($urandom_range(127));
        end
        return t_unit'($urandom_range(65535));
    endfunction

    function automatic t_unit flip_case(t_unit c);
        t_unit lowered;
        lowered = c | (CHAR_LOWER_A ^ CHAR_UPPER_A);
        if (lowered >= CHAR_LOWER_A && lowered <= CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A)
                && c[15:7] == '0 && $urandom_range(1)) begin
            return c ^ (CHAR_LOWER_A ^ CHAR_UPPER_A);
        end
        return c;
    endfunction

    task automatic run_query();
        t_unit       ndl [$];
        t_unit       hay [$];
        int unsigned r;
        int unsigned nlen;
        int unsigned hlen;
        int unsigned pos;
        int unsigned n_early;
        int unsigned h_early;
        r = $urandom_range(99);
        if (r < 5) begin
            nlen = $urandom_range(NEEDLE_DEPTH + 3, NEEDLE_DEPTH + 1);
        end else if (r < 15) begin
            nlen = 0;
        end else if (r < 25) begin
            nlen = $urandom_range(NEEDLE_DEPTH, 5);
        end else begin
            nlen = $urandom_range(4, 1);
        end
        hlen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (nlen) ndl.push_back(pick_unit());
        repeat (hlen) hay.push_back(pick_unit());
        if (nlen > 0 && nlen <= hlen && $urandom_range(99) < 45) begin
            pos = $urandom_range(hlen - nlen);
            for (int i = 0; i < nlen; i++) hay[pos+i] = flip_case(ndl[i]);
        end
        n_early = nlen;
        h_early = 0;
        if (nlen > 0 && $urandom_range(9) == 0) begin
            n_early = $urandom_range(nlen - 1);
            h_early = $urandom_range(hlen);
        end
        if ($urandom_range(19) != 0) send_unit(KIND_START, t_unit'($urandom_range(65535)));
        for (int i = 0; i < n_early; i++) send_unit(KIND_NEEDLE, ndl[i]);
        for (int i = 0; i < h_early; i++) send_unit(KIND_HAYSTACK, hay[i]);
        for (int i = n_early; i < nlen; i++) send_unit(KIND_NEEDLE, ndl[i]);
        for (int i = h_early; i < hlen; i++) send_unit(KIND_HAYSTACK, hay[i]);
        send_finish($urandom_range(99) < 8, $urandom_range(99) < 8);
        if ($urandom_range(9) == 0) send_finish($urandom_range(99) < 8, $urandom_range(99) < 8);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 1)) begin
            send_unit(t_kind'($urandom_range(3)), t_unit'($urandom_range(65535)));
        end
    endtask

    // With the report channel held off, a run of finish beats fills the
    // output and input registers so that the block has to stall its input.
    task automatic hold_burst();
        hold_request = 1'b1;
        send_unit(KIND_START, CHAR_LOWER_A);
        send_unit(KIND_NEEDLE, CHAR_LOWER_A);
        send_unit(KIND_HAYSTACK, CHAR_UPPER_A);
        repeat (3) send_finish(1'b0, 1'b0);
        send_unit(KIND_HAYSTACK, CHAR_LOWER_A);
        send_finish(1'b0, 1'b0);
        send_finish(1'b0, 1'b1);
    endtask

    initial begin
        t_mode phase_modes [8];
        int unsigned phase_end;
        phase_modes = '{MODE_EXACT_A, MODE_FOLD_A, MODE_EXACT_B, MODE_FOLD_B,
                        MODE_RESET, MODE_FOLD_C, MODE_EXACT_C, MODE_EXACT_D};

        i_rst_n                   = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.compare_mode      = '0;
        item_bus.valid            = 1'b0;
        item_bus.kind             = KIND_START;
        item_bus.char_code        = '0;
        item_bus.haystack_missing = 1'b0;
        item_bus.needle_missing   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_GAP) @(posedge i_clk);

        // Exact comparison straight out of reset.
        send_finish(1'b0, 1'b0);
        send_unit(KIND_START, 16'hFFFF);
        send_unit(KIND_NEEDLE, CHAR_UPPER_A);
        send_unit(KIND_NEEDLE, 16'hFFFF);
        send_unit(KIND_HAYSTACK, 16'h0000);
        send_unit(KIND_HAYSTACK, CHAR_UPPER_A);
        send_unit(KIND_HAYSTACK, 16'hFFFF);
        send_finish(1'b0, 1'b0);
        send_finish(1'b1, 1'b1);
        send_finish(1'b0, 1'b1);
        send_unit(KIND_START, 16'h0000);
        send_unit(KIND_HAYSTACK, t_unit'(CHAR_LOWER_A + 16));
        send_unit(KIND_NEEDLE, t_unit'(CHAR_LOWER_A + 16));
        send_finish(1'b0, 1'b0);
        send_unit(KIND_HAYSTACK, t_unit'(CHAR_LOWER_A + 16));
        send_finish(1'b0, 1'b0);
        drain();

        // Case folding at the edges of the letter range.
        write_mode(MODE_FOLD_C);
        send_unit(KIND_START, 16'h0000);
        send_unit(KIND_NEEDLE, CHAR_UPPER_Z);
        send_unit(KIND_NEEDLE, t_unit'(CHAR_UPPER_Z + 1));
        send_unit(KIND_HAYSTACK, CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A));
        send_unit(KIND_HAYSTACK, t_unit'(CHAR_UPPER_Z + 1));
        send_finish(1'b0, 1'b0);
        send_unit(KIND_START, 16'h0000);
        send_unit(KIND_NEEDLE, t_unit'(CHAR_UPPER_A - 1));
        send_unit(KIND_NEEDLE, CHAR_UPPER_A);
        send_unit(KIND_HAYSTACK, t_unit'(CHAR_LOWER_A - 1));
        send_finish(1'b0, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            write_mode(phase_modes[phase]);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            if (phase == 0) hold_burst();
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(9) == 0) begin
                    send_noise();
                end else begin
                    run_query();
                end
                if (phase == 3 && items_sent >= phase_end - PHASE_ITEMS / 2
                        && items_sent < phase_end - PHASE_ITEMS / 2 + 20) begin
                    drain();
                end
            end
        end

        drain();
        $display("Sent %0d query beats over all eight compare modes and four idling patterns.",
                 items_sent);
        $display("Checked %0d reports, with %0d mismatches.",
                 tracker.reports_checked, tracker.errors);
        if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
